[rtl/most_frequent_byte_finder_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the byte histogram mode finder
// Each macro checks on the rising edge of clk_i while out of reset.
// ---------------------------------------------------------------------------
`ifndef MOST_FREQUENT_BYTE_FINDER_MACROS_SVH
`define MOST_FREQUENT_BYTE_FINDER_MACROS_SVH

// Property holds on every clock edge outside reset
`define MFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define MFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mfb_pkg.sv]
// ---------------------------------------------------------------------------
// mfb_pkg
// Types and constants shared by the byte histogram mode finder.
// ---------------------------------------------------------------------------
package mfb_pkg;

  // Longest string that is counted; later bytes are dropped
  localparam int MaxLen   = 256;
  localparam int PosW     = $clog2(MaxLen + 1);
  localparam int FpW      = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int CountW   = 9;
  localparam int Entries  = 256;
  localparam logic [CountW-1:0] CountMax = '1;

  // Input word
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [7:0]        mode_byte;
    logic [CountW-1:0] mode_count;
    logic              truncated;
  } out_word_t;

  // One histogram entry
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [FpW-1:0]    first_pos;
  } entry_t;

  // Byte in flight between the front end and the update stage
  typedef struct packed {
    logic [7:0]     byte_val;
    logic           last;
    logic           counted;
    logic           truncated;
    logic [FpW-1:0] pos;
  } tag_t;

endpackage

[rtl/mfb_entry_ram.sv]
// ---------------------------------------------------------------------------
// mfb_entry_ram
// Histogram store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mfb_entry_ram
  import mfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  entry_t     wdata_i,
  input  logic       re_i,
  input  logic [7:0] raddr_i,
  output entry_t     rdata_o
);

  entry_t mem [Entries];
  entry_t rdata_q;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mfb_track.sv]
// ---------------------------------------------------------------------------
// mfb_track
// Front end: string position, length limit and truncation flag, and the
// register that carries each accepted byte into the update stage.
// ---------------------------------------------------------------------------
module mfb_track
  import mfb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic     fire_i,
  input  in_word_t word_i,
  output logic     tag_valid_o,
  output tag_t     tag_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            ovf_q, ovf_d;
  logic            tag_valid_q, tag_valid_d;
  tag_t            tag_q, tag_d;
  logic            counted;

  assign counted = (pos_q < PosW'(MaxLen));

  // Position and overflow bookkeeping per accepted byte
  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    tag_d = tag_q;
    tag_valid_d = tag_valid_q;
    if (fire_i) begin
      tag_valid_d = 1'b0;
    end
    if (accept_i) begin
      tag_valid_d       = 1'b1;
      tag_d.byte_val    = word_i.byte_in;
      tag_d.last        = word_i.last_byte;
      tag_d.counted     = counted;
      tag_d.truncated   = ovf_q | ~counted;
      tag_d.pos         = pos_q[FpW-1:0];
      if (word_i.last_byte) begin
        pos_d = '0;
        ovf_d = 1'b0;
      end else begin
        if (counted) begin
          pos_d = pos_q + PosW'(1);
        end
        ovf_d = ovf_q | ~counted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      tag_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      tag_valid_q <= tag_valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign tag_valid_o = tag_valid_q;
  assign tag_o       = tag_q;

endmodule

[rtl/mfb_update.sv]
// ---------------------------------------------------------------------------
// mfb_update
// Read-modify-write stage: entry valid bits, write forwarding, running
// best and the result register.
// ---------------------------------------------------------------------------
`include "most_frequent_byte_finder_macros.svh"

module mfb_update
  import mfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tag_valid_i,
  input  tag_t       tag_i,
  input  entry_t     rdata_i,
  output logic       hold_o,
  output logic       fire_o,
  output logic       we_o,
  output logic [7:0] waddr_o,
  output entry_t     wdata_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  logic [Entries-1:0] valid_q, valid_d;
  logic               fwd_valid_q;
  logic [7:0]         fwd_addr_q;
  entry_t             fwd_data_q;
  logic [7:0]         best_byte_q, best_byte_d;
  logic [CountW-1:0]  best_cnt_q, best_cnt_d;
  logic [FpW-1:0]     best_fp_q, best_fp_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;
  entry_t             cur, upd;
  logic               hit, better, hold, fire, we;

  // A finished result blocks only the next end-of-string byte
  assign hold = tag_valid_i & tag_i.last & out_valid_q & out_stall_i;
  assign fire = tag_valid_i & ~hold;
  assign we   = fire & tag_i.counted;

  // Latest write wins over the stale read data
  assign hit = valid_q[tag_i.byte_val];
  assign cur = (fwd_valid_q && (fwd_addr_q == tag_i.byte_val)) ? fwd_data_q : rdata_i;

  // New count and first position
  always_comb begin
    if (hit) begin
      upd.count     = (cur.count == CountMax) ? cur.count : cur.count + CountW'(1);
      upd.first_pos = cur.first_pos;
    end else begin
      upd.count     = CountW'(1);
      upd.first_pos = tag_i.pos;
    end
  end

  assign better = (upd.count > best_cnt_q) ||
                  ((upd.count == best_cnt_q) && (upd.first_pos < best_fp_q));

  // Running best, valid bits and result register
  always_comb begin
    valid_d     = valid_q;
    best_byte_d = best_byte_q;
    best_cnt_d  = best_cnt_q;
    best_fp_d   = best_fp_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_word_d  = out_word_q;
    if (we) begin
      valid_d[tag_i.byte_val] = 1'b1;
      if (better) begin
        best_byte_d = tag_i.byte_val;
        best_cnt_d  = upd.count;
        best_fp_d   = upd.first_pos;
      end
    end
    if (fire && tag_i.last) begin
      out_valid_d           = 1'b1;
      out_word_d.mode_byte  = best_byte_d;
      out_word_d.mode_count = best_cnt_d;
      out_word_d.truncated  = tag_i.truncated;
      valid_d               = '0;
      best_byte_d           = '0;
      best_cnt_d            = '0;
      best_fp_d             = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fwd_valid_q <= 1'b0;
      best_byte_q <= '0;
      best_cnt_q  <= '0;
      best_fp_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      best_byte_q <= best_byte_d;
      best_cnt_q  <= best_cnt_d;
      best_fp_q   <= best_fp_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  // Forwarding copy of the last write and result payload
  always_ff @(posedge clk_i) begin
    if (we) begin
      fwd_addr_q <= tag_i.byte_val;
      fwd_data_q <= upd;
    end
    out_word_q <= out_word_d;
  end

  assign hold_o      = hold;
  assign fire_o      = fire;
  assign we_o        = we;
  assign waddr_o     = tag_i.byte_val;
  assign wdata_o     = upd;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Checks
  `MFB_ASSERT(a_no_write_on_hold, hold |-> !we, "write while held")
  `MFB_ASSERT_NEXT(a_best_clear, fire && tag_i.last, best_cnt_q == '0, "best not cleared")
  `MFB_ASSERT(a_best_bound, best_cnt_q <= CountW'(MaxLen), "best count above limit")
  `MFB_ASSERT(a_result_nonzero, out_valid_q |-> out_word_q.mode_count != '0, "empty result")

endmodule

[rtl/most_frequent_byte_finder.sv]
// A result is registered on out_valid_o when its last byte fires in the update stage.
// Throughput: one byte per cycle while not stalled; each byte reads its RAM entry and
//   the update stage writes it back, with forwarding of the last write.
// A pending result stalls input only when another last byte reaches the update stage.
// Reset: asynchronous, clears position, best, entry valid bits and output valid;
//   the histogram RAM needs no clearing pass.
// ---------------------------------------------------------------------------
// most_frequent_byte_finder
// Byte histogram mode: reports the most frequent byte of each string and its count.
// ---------------------------------------------------------------------------
module most_frequent_byte_finder
  import mfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic       accept, hold, fire, tag_valid, we;
  tag_t       tag;
  logic [7:0] waddr;
  entry_t     wdata, rdata;

  // Input handshake
  assign accept     = in_valid_i & ~hold;
  assign in_stall_o = hold;

  mfb_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .fire_i      (fire),
    .word_i      (in_word_i),
    .tag_valid_o (tag_valid),
    .tag_o       (tag)
  );

  mfb_entry_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (in_word_i.byte_in),
    .rdata_o (rdata)
  );

  mfb_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_valid_i (tag_valid),
    .tag_i       (tag),
    .rdata_i     (rdata),
    .hold_o      (hold),
    .fire_o      (fire),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
